### hdl/epfp_pkg.sv
package epfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OUT_W   = 40;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_BEGIN_CODE = 2'd0;
  localparam logic [1:0] REG_LEFT_CODE  = 2'd1;
  localparam logic [1:0] REG_RIGHT_CODE = 2'd2;

  localparam logic [CODE_W-1:0] BEGIN_CODE_RST = 2'd0;
  localparam logic [CODE_W-1:0] LEFT_CODE_RST  = 2'd1;
  localparam logic [CODE_W-1:0] RIGHT_CODE_RST = 2'd3;

  localparam logic [BYTE_W-1:0] INDEX_RST  = 8'hFF;
  localparam logic [BYTE_W-1:0] INDEX_GOOD = 8'h11;
  localparam logic [BYTE_W-1:0] BEGIN_STEP = 8'h01;
  localparam logic [BYTE_W-1:0] SIDE_STEP  = 8'h10;

  typedef struct packed {
    logic [COUNT_W-1:0] right_count;
    logic [COUNT_W-1:0] left_count;
    logic               frame_error;
    logic               pair_ready;
    logic               accepted;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

### hdl/encoder_pair_frame_parser.sv
// encoder pair frame parser
//
// s_* channel: one received serial byte per request (s_tdata = rx_byte).
// m_* channel: one result per accepted byte; m_tdata holds, from bit 0 up,
// accepted, pair_ready, frame_error, left_count[15:0], right_count[15:0],
// then five zero bits.
// apb port: begin_code at 0x0, left_code at 0x4, right_code at 0x8, two bits
// each; write only while the stream is idle.
//
// a result goes to the output register if it is free or popped, else to the
// skid register. one byte per cycle is taken while s_tready is high; the frame
// state lives in a handful of registers updated in the cycle of acceptance.
// the result side has an output register plus one skid register, so a byte
// is still taken while one result waits; s_tready drops only once the skid
// register is full and comes back the cycle after the receiver takes one.
// reset (rst, synchronous) empties both result registers, restores the default
// codes, sets the frame index to 0xff and marks the right side valid and last.
module encoder_pair_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [epfp_pkg::BYTE_W-1:0]   s_tdata,   // rx_byte[7:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // accepted, pair_ready, frame_error, left_count[15:0], right_count[15:0], pad
  output logic [epfp_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [epfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [epfp_pkg::DATA_W-1:0]   pwdata,
  output logic [epfp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [epfp_pkg::CODE_W-1:0]  begin_code;
  logic [epfp_pkg::CODE_W-1:0]  left_code;
  logic [epfp_pkg::CODE_W-1:0]  right_code;

  logic [epfp_pkg::BYTE_W-1:0]  frame_index, frame_index_next;
  logic [epfp_pkg::BYTE_W-1:0]  work_high, work_high_next;
  logic [epfp_pkg::BYTE_W-1:0]  work_low, work_low_next;
  logic [epfp_pkg::COUNT_W-1:0] held_right, held_right_next;
  logic                         last_side_right, last_side_right_next;
  logic                         right_valid, right_valid_next;
  logic [epfp_pkg::COUNT_W-1:0] published_left, published_left_next;
  logic [epfp_pkg::COUNT_W-1:0] published_right, published_right_next;

  epfp_pkg::result_t            result_next;
  epfp_pkg::result_t            out_data;
  epfp_pkg::result_t            skid_data;
  logic                         out_valid;
  logic                         skid_valid;

  logic [epfp_pkg::CODE_W-1:0]  code;
  logic [epfp_pkg::BYTE_W-1:0]  low_sum;
  logic                         push;
  logic                         pop;
  logic                         cfg_write;

  assign push      = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;
  assign s_tready  = !skid_valid;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(epfp_pkg::OUT_W - epfp_pkg::RESULT_W){1'b0}}, out_data};
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      epfp_pkg::REG_BEGIN_CODE: prdata = {{(epfp_pkg::DATA_W - epfp_pkg::CODE_W){1'b0}}, begin_code};
      epfp_pkg::REG_LEFT_CODE:  prdata = {{(epfp_pkg::DATA_W - epfp_pkg::CODE_W){1'b0}}, left_code};
      epfp_pkg::REG_RIGHT_CODE: prdata = {{(epfp_pkg::DATA_W - epfp_pkg::CODE_W){1'b0}}, right_code};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_code <= epfp_pkg::BEGIN_CODE_RST;
      left_code  <= epfp_pkg::LEFT_CODE_RST;
      right_code <= epfp_pkg::RIGHT_CODE_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        epfp_pkg::REG_BEGIN_CODE: begin_code <= pwdata[epfp_pkg::CODE_W-1:0];
        epfp_pkg::REG_LEFT_CODE:  left_code  <= pwdata[epfp_pkg::CODE_W-1:0];
        epfp_pkg::REG_RIGHT_CODE: right_code <= pwdata[epfp_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign code    = s_tdata[7:6];
  assign low_sum = work_low + {3'b000, s_tdata[4:0]};

  always_comb begin
    frame_index_next     = frame_index;
    work_high_next       = work_high;
    work_low_next        = work_low;
    held_right_next      = held_right;
    last_side_right_next = last_side_right;
    right_valid_next     = right_valid;
    published_left_next  = published_left;
    published_right_next = published_right;
    result_next          = '0;
    result_next.accepted = 1'b1;

    // begin code wins over left, left over right
    priority if (code == begin_code) begin
      if (!s_tdata[5]) begin
        work_high_next   = {s_tdata[4:0], 3'b000};
        frame_index_next = frame_index + epfp_pkg::BEGIN_STEP;
      end else begin
        if (frame_index != epfp_pkg::INDEX_GOOD) begin
          result_next.frame_error = 1'b1;
          if (last_side_right) begin
            right_valid_next = 1'b0;
          end
        end else if (!last_side_right && !right_valid) begin
          // left frame without a valid right one is dropped
        end else begin
          work_low_next = low_sum;
          if (last_side_right) begin
            right_valid_next = 1'b1;
            held_right_next  = {work_high, low_sum};
          end else begin
            published_left_next    = {work_high, low_sum};
            published_right_next   = held_right;
            result_next.pair_ready = 1'b1;
            right_valid_next       = 1'b0;
          end
        end
        frame_index_next = '0;
      end
    end else if (code == left_code || code == right_code) begin
      last_side_right_next = (code != left_code);
      work_high_next       = work_high + {5'b00000, s_tdata[5:3]};
      work_low_next        = {s_tdata[2:0], 5'b00000};
      frame_index_next     = frame_index + epfp_pkg::SIDE_STEP;
    end else begin
      result_next.accepted = 1'b0;
    end

    result_next.left_count  = published_left_next;
    result_next.right_count = published_right_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index     <= epfp_pkg::INDEX_RST;
      work_high       <= '0;
      work_low        <= '0;
      held_right      <= '0;
      last_side_right <= 1'b1;
      right_valid     <= 1'b1;
      published_left  <= '0;
      published_right <= '0;
    end else if (push) begin
      frame_index     <= frame_index_next;
      work_high       <= work_high_next;
      work_low        <= work_low_next;
      held_right      <= held_right_next;
      last_side_right <= last_side_right_next;
      right_valid     <= right_valid_next;
      published_left  <= published_left_next;
      published_right <= published_right_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= result_next;
      end else begin
        skid_data <= result_next;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_ready_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_data.pair_ready && out_data.frame_error))
    else $error("pair published on a bad frame");

  a_ready_accepted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_data.pair_ready || out_data.frame_error) |-> out_data.accepted)
    else $error("flag raised for an unaccepted byte");

  a_pair_clears_right: assert property (@(posedge clk) disable iff (rst)
    push && result_next.pair_ready |=> !right_valid)
    else $error("right side still valid after publishing a pair");

endmodule
